/* rtl/q2e_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants and the arctangent table of the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int QUAT_W        = 16;
   localparam int PROD_W        = 32;
   localparam int TERM_W        = 34;
   localparam int MAG_W         = 30;
   localparam int SQ_W          = 60;
   localparam int RAD_W         = 61;
   localparam int RES_W         = 62;
   localparam int ROOT_W        = 31;
   localparam int SQRT_STEPS    = 31;
   localparam int CORDIC_W      = 40;
   localparam int ANG_W         = 28;
   localparam int RND_W         = 18;
   localparam int CORDIC_STEPS  = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_STAGES =
      (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int FRONT_LAT     = 4;
   localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
   localparam int TOTAL_LAT     = FRONT_LAT + SQRT_STEPS + CORDIC_LAT + 1;

   localparam logic signed [TERM_W-1:0] ONE_Q30     = TERM_W'(64'sd1073741824);
   localparam logic signed [TERM_W-1:0] NEG_ONE_Q30 = -ONE_Q30;
   localparam logic signed [ANG_W-1:0]  DEG180_Q16  = ANG_W'(180 * 65536);
   localparam logic signed [RND_W-1:0]  ANGLE_LIMIT = RND_W'(23040);
   localparam logic signed [RND_W-1:0]  PITCH_LIMIT = RND_W'(11520);

   typedef struct packed {
      logic signed [TERM_W-1:0] roll_y;
      logic signed [TERM_W-1:0] roll_x;
      logic signed [TERM_W-1:0] yaw_y;
      logic signed [TERM_W-1:0] yaw_x;
      logic signed [TERM_W-1:0] sin_p;
      logic                     clamp_pos;
      logic                     clamp_neg;
   } term_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         0:       val = ANG_W'(2949120);
         1:       val = ANG_W'(1740967);
         2:       val = ANG_W'(919879);
         3:       val = ANG_W'(466945);
         4:       val = ANG_W'(234379);
         5:       val = ANG_W'(117304);
         6:       val = ANG_W'(58666);
         7:       val = ANG_W'(29335);
         8:       val = ANG_W'(14668);
         9:       val = ANG_W'(7334);
         10:      val = ANG_W'(3667);
         11:      val = ANG_W'(1833);
         12:      val = ANG_W'(917);
         13:      val = ANG_W'(458);
         14:      val = ANG_W'(229);
         15:      val = ANG_W'(115);
         16:      val = ANG_W'(57);
         17:      val = ANG_W'(29);
         18:      val = ANG_W'(14);
         19:      val = ANG_W'(7);
         20:      val = ANG_W'(4);
         21:      val = ANG_W'(2);
         22:      val = ANG_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

/* rtl/q2e_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_front
// Products of the quaternion components, the atan2 operands, the pitch sine
// and the radicand of the pitch cosine, over four register stages.
// ----------------------------------------------------------------------------
module q2e_front (
   input  wire                                      clock,
   input  wire                                      enable,
   input  wire  logic signed [q2e_pkg::QUAT_W-1:0] quat_x,
   input  wire  logic signed [q2e_pkg::QUAT_W-1:0] quat_y,
   input  wire  logic signed [q2e_pkg::QUAT_W-1:0] quat_z,
   input  wire  logic signed [q2e_pkg::QUAT_W-1:0] quat_w,
   output q2e_pkg::term_type                        terms,
   output logic [q2e_pkg::RAD_W-1:0]                rad
);

   logic signed [q2e_pkg::PROD_W-1:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff;
   logic signed [q2e_pkg::PROD_W-1:0] p_wz_ff, p_xy_ff, p_zz_ff, p_wy_ff, p_zx_ff;
   q2e_pkg::term_type                 terms_in, terms_b_ff, terms_c_ff, terms_d_ff;
   logic signed [q2e_pkg::TERM_W-1:0] sin_abs;
   logic [q2e_pkg::MAG_W-1:0]         mag;
   logic [q2e_pkg::SQ_W-1:0]          sq_in, sq_ff;
   logic [q2e_pkg::RAD_W-1:0]         rad_in, rad_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         p_wx_ff <= quat_w * quat_x;
         p_yz_ff <= quat_y * quat_z;
         p_xx_ff <= quat_x * quat_x;
         p_yy_ff <= quat_y * quat_y;
         p_wz_ff <= quat_w * quat_z;
         p_xy_ff <= quat_x * quat_y;
         p_zz_ff <= quat_z * quat_z;
         p_wy_ff <= quat_w * quat_y;
         p_zx_ff <= quat_z * quat_x;
      end
   end

   always_comb begin
      terms_in.roll_y = (q2e_pkg::TERM_W'(p_wx_ff) + q2e_pkg::TERM_W'(p_yz_ff)) <<< 1;
      terms_in.roll_x = q2e_pkg::ONE_Q30 -
                        ((q2e_pkg::TERM_W'(p_xx_ff) + q2e_pkg::TERM_W'(p_yy_ff)) <<< 1);
      terms_in.yaw_y  = (q2e_pkg::TERM_W'(p_wz_ff) + q2e_pkg::TERM_W'(p_xy_ff)) <<< 1;
      terms_in.yaw_x  = q2e_pkg::ONE_Q30 -
                        ((q2e_pkg::TERM_W'(p_yy_ff) + q2e_pkg::TERM_W'(p_zz_ff)) <<< 1);
      terms_in.sin_p  = (q2e_pkg::TERM_W'(p_wy_ff) - q2e_pkg::TERM_W'(p_zx_ff)) <<< 1;
      terms_in.clamp_pos = terms_in.sin_p >= q2e_pkg::ONE_Q30;
      terms_in.clamp_neg = terms_in.sin_p <= q2e_pkg::NEG_ONE_Q30;
   end

   // Only the unclamped sine matters, and its magnitude is below two to the 30.
   assign sin_abs = terms_b_ff.sin_p[q2e_pkg::TERM_W-1] ? -terms_b_ff.sin_p
                                                        : terms_b_ff.sin_p;
   assign mag     = sin_abs[q2e_pkg::MAG_W-1:0];
   assign sq_in   = q2e_pkg::SQ_W'(mag) * q2e_pkg::SQ_W'(mag);
   assign rad_in  = (q2e_pkg::RAD_W'(1) << q2e_pkg::SQ_W) - q2e_pkg::RAD_W'(sq_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         terms_b_ff <= terms_in;
         terms_c_ff <= terms_b_ff;
         sq_ff      <= sq_in;
         terms_d_ff <= terms_c_ff;
         rad_ff     <= rad_in;
      end
   end

   assign terms = terms_d_ff;
   assign rad   = rad_ff;

endmodule
`default_nettype wire

/* rtl/q2e_isqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module q2e_isqrt (
   input  wire                                clock,
   input  wire                                enable,
   input  wire  logic [q2e_pkg::RAD_W-1:0]   rad,
   output logic [q2e_pkg::ROOT_W-1:0]         root
);

   logic [q2e_pkg::RES_W-1:0] rem_ff [q2e_pkg::SQRT_STEPS];
   logic [q2e_pkg::RES_W-1:0] res_ff [q2e_pkg::SQRT_STEPS];

   for (genvar k = 0; k < q2e_pkg::SQRT_STEPS; k++) begin : g_step
      localparam logic [q2e_pkg::RES_W-1:0] BIT =
         q2e_pkg::RES_W'(1) << (q2e_pkg::RAD_W - 1 - 2 * k);
      logic [q2e_pkg::RES_W-1:0] rem_prev, res_prev, trial, rem_in, res_in;

      if (k == 0) begin : g_first
         assign rem_prev = q2e_pkg::RES_W'(rad);
         assign res_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in = rem_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            rem_in = rem_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign root = res_ff[q2e_pkg::SQRT_STEPS-1][q2e_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

/* rtl/q2e_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined CORDIC vectoring atan2 giving degrees times 128, rounded.
// ----------------------------------------------------------------------------
module q2e_cordic (
   input  wire                                       clock,
   input  wire                                       enable,
   input  wire  logic signed [q2e_pkg::TERM_W-1:0]  ys,
   input  wire  logic signed [q2e_pkg::TERM_W-1:0]  xs,
   output logic signed [q2e_pkg::RND_W-1:0]          angle
);

   localparam int N = q2e_pkg::CORDIC_STAGES;

   logic signed [q2e_pkg::CORDIC_W-1:0] px_ff [N+1];
   logic signed [q2e_pkg::CORDIC_W-1:0] py_ff [N+1];
   logic signed [q2e_pkg::ANG_W-1:0]    ang_ff [N+1];
   logic                                zero_ff [N+1];
   logic signed [q2e_pkg::CORDIC_W-1:0] xe, ye;
   logic signed [q2e_pkg::ANG_W-1:0]    rnd_sum;
   logic signed [q2e_pkg::RND_W-1:0]    angle_in, angle_ff;

   assign xe = q2e_pkg::CORDIC_W'(xs);
   assign ye = q2e_pkg::CORDIC_W'(ys);

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (xs == '0) && (ys == '0);
         if (xs < 0) begin
            px_ff[0]  <= -xe;
            py_ff[0]  <= -ye;
            ang_ff[0] <= (ys >= 0) ? q2e_pkg::DEG180_Q16 : -q2e_pkg::DEG180_Q16;
         end else begin
            px_ff[0]  <= xe;
            py_ff[0]  <= ye;
            ang_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      localparam logic signed [q2e_pkg::ANG_W-1:0] STEP = q2e_pkg::atan_entry(i);
      logic signed [q2e_pkg::CORDIC_W-1:0] dx, dy;

      assign dx = py_ff[i] >>> i;
      assign dy = px_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (enable) begin
            zero_ff[i+1] <= zero_ff[i];
            if (py_ff[i] >= 0) begin
               px_ff[i+1]  <= px_ff[i] + dx;
               py_ff[i+1]  <= py_ff[i] - dy;
               ang_ff[i+1] <= ang_ff[i] + STEP;
            end else begin
               px_ff[i+1]  <= px_ff[i] - dx;
               py_ff[i+1]  <= py_ff[i] + dy;
               ang_ff[i+1] <= ang_ff[i] - STEP;
            end
         end
      end
   end

   assign rnd_sum  = (ang_ff[N] + q2e_pkg::ANG_W'(256)) >>> 9;
   assign angle_in = zero_ff[N] ? '0 : rnd_sum[q2e_pkg::RND_W-1:0];

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule
`default_nettype wire

/* rtl/quaternion_to_euler_angles_unit.sv */
// Throughput: one request per cycle while results are taken; the square
// root and CORDIC are fully pipelined, one bit or micro-rotation per
// stage.
// A result that is not taken freezes the whole pipeline until it is taken.
// Reset clears the valid bits only; no request is in flight afterwards.
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Converts a Q1.15 quaternion into roll, pitch and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [63:0]  req_tdata,  // quat_x, quat_y, quat_z, quat_w
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [47:0]  rsp_tdata,  // roll_angle, pitch_angle, yaw_angle, zero pad
   output logic [0:0]   rsp_tuser   // pitch_clamped
);

   localparam int L  = q2e_pkg::TOTAL_LAT;
   localparam int SL = q2e_pkg::SQRT_STEPS;
   localparam int CL = q2e_pkg::CORDIC_LAT;

   logic                              adv;
   logic                              vld_ff [L];
   q2e_pkg::term_type                 terms;
   q2e_pkg::term_type                 side_ff [SL];
   logic [1:0]                        flag_ff [CL];
   logic [q2e_pkg::RAD_W-1:0]         rad;
   logic [q2e_pkg::ROOT_W-1:0]        root;
   logic signed [q2e_pkg::RND_W-1:0]  roll_r, pitch_r, yaw_r;
   logic signed [q2e_pkg::RND_W-1:0]  roll_in, pitch_in, yaw_in;
   logic signed [15:0]                roll_ff, yaw_ff;
   logic signed [14:0]                pitch_ff;
   logic                              clamp_ff;
   q2e_pkg::term_type                 side_last;

   assign adv        = !vld_ff[L-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < L; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int k = 1; k < L; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   q2e_front u_front (
      .clock  (clock),
      .enable (adv),
      .quat_x (req_tdata[15:0]),
      .quat_y (req_tdata[31:16]),
      .quat_z (req_tdata[47:32]),
      .quat_w (req_tdata[63:48]),
      .terms  (terms),
      .rad    (rad)
   );

   q2e_isqrt u_isqrt (
      .clock  (clock),
      .enable (adv),
      .rad    (rad),
      .root   (root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= terms;
         for (int k = 1; k < SL; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         flag_ff[0] <= {side_ff[SL-1].clamp_neg, side_ff[SL-1].clamp_pos};
         for (int k = 1; k < CL; k++) begin
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   assign side_last = side_ff[SL-1];

   q2e_cordic u_roll (
      .clock  (clock),
      .enable (adv),
      .ys     (side_last.roll_y),
      .xs     (side_last.roll_x),
      .angle  (roll_r)
   );

   q2e_cordic u_pitch (
      .clock  (clock),
      .enable (adv),
      .ys     (side_last.sin_p),
      .xs     (q2e_pkg::TERM_W'(root)),
      .angle  (pitch_r)
   );

   q2e_cordic u_yaw (
      .clock  (clock),
      .enable (adv),
      .ys     (side_last.yaw_y),
      .xs     (side_last.yaw_x),
      .angle  (yaw_r)
   );

   always_comb begin
      roll_in = roll_r;
      if (roll_r > q2e_pkg::ANGLE_LIMIT) begin
         roll_in = q2e_pkg::ANGLE_LIMIT;
      end else if (roll_r < -q2e_pkg::ANGLE_LIMIT) begin
         roll_in = -q2e_pkg::ANGLE_LIMIT;
      end
      yaw_in = yaw_r;
      if (yaw_r > q2e_pkg::ANGLE_LIMIT) begin
         yaw_in = q2e_pkg::ANGLE_LIMIT;
      end else if (yaw_r < -q2e_pkg::ANGLE_LIMIT) begin
         yaw_in = -q2e_pkg::ANGLE_LIMIT;
      end
      pitch_in = pitch_r;
      if (flag_ff[CL-1][0] || pitch_r > q2e_pkg::PITCH_LIMIT) begin
         pitch_in = q2e_pkg::PITCH_LIMIT;
      end else if (flag_ff[CL-1][1] || pitch_r < -q2e_pkg::PITCH_LIMIT) begin
         pitch_in = -q2e_pkg::PITCH_LIMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= roll_in[15:0];
         pitch_ff <= pitch_in[14:0];
         yaw_ff   <= yaw_in[15:0];
         clamp_ff <= |flag_ff[CL-1];
      end
   end

   assign rsp_tvalid = vld_ff[L-1];
   assign rsp_tdata  = {1'b0, yaw_ff, pitch_ff, roll_ff};
   assign rsp_tuser  = clamp_ff;

endmodule
`default_nettype wire

/* tb/sv/tb_quaternion_to_euler_angles_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_unit
// Streams quaternions through the converter with random gaps on both sides
// and checks every roll, pitch, yaw and clamp flag result against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_unit;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [15:0] w;
   } quat_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } euler_type;

   localparam longint ONE_Q30_L = 64'sd1 << 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   bit     failed = 1'b0;
   bit     req_taken = 1'b0;
   int     sent_count = 0;
   int     result_count = 0;
   int     req_gap = 0;
   int     rsp_gap = 0;
   int     rsp_hold = 0;
   bit     hold_done = 1'b0;

   quaternion_to_euler_angles_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic longint arctan_q16(input int idx);
      longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
      return tab[idx];
   endfunction

   function automatic longint atan2_deg128(input longint ys, input longint xs,
                                           input longint lim);
      longint px, py, ang, dx, dy;
      px = xs;
      py = ys;
      ang = 0;
      if (px == 0 && py == 0) return 0;
      if (px < 0) begin
         ang = (py >= 0) ? 180 * 65536 : -180 * 65536;
         px = -px;
         py = -py;
      end
      for (int i = 0; i < q2e_pkg::CORDIC_STAGES; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px += dx;
            py -= dy;
            ang += arctan_q16(i);
         end else begin
            px -= dx;
            py += dy;
            ang -= arctan_q16(i);
         end
      end
      ang = (ang + 256) >>> 9;
      if (ang > lim) ang = lim;
      if (ang < -lim) ang = -lim;
      return ang;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned rem, res, bitv;
      rem = v;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic euler_type quat_to_euler(input quat_type q);
      longint qx, qy, qz, qw, r, p, yw, sp;
      longint unsigned c;
      euler_type e;
      qx = q.x;
      qy = q.y;
      qz = q.z;
      qw = q.w;
      r  = atan2_deg128(2 * (qw * qx + qy * qz), ONE_Q30_L - 2 * (qx * qx + qy * qy),
                        23040);
      yw = atan2_deg128(2 * (qw * qz + qx * qy), ONE_Q30_L - 2 * (qy * qy + qz * qz),
                        23040);
      sp = 2 * (qw * qy - qz * qx);
      e.clamped = 1'b0;
      if (sp >= ONE_Q30_L) begin
         p = 11520;
         e.clamped = 1'b1;
      end else if (sp <= -ONE_Q30_L) begin
         p = -11520;
         e.clamped = 1'b1;
      end else begin
         c = int_sqrt((64'd1 << 60) - longint'(sp * sp));
         p = atan2_deg128(sp, longint'(c), 11520);
      end
      e.roll  = r[15:0];
      e.pitch = p[14:0];
      e.yaw   = yw[15:0];
      return e;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic quat_type random_quat();
      quat_type q;
      int kind;
      kind = $urandom_range(0, 9);
      q = {$urandom, $urandom};
      q.w = 16'($urandom);
      case (kind)
         0, 1, 2: ;
         3, 4: begin
            q.x = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            q.y = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            q.z = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            q.w = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
         end
         5, 6: begin
            q.w = $signed(16'($urandom_range(22900, 23400)));
            q.y = $urandom_range(0, 1) ? $signed(16'($urandom_range(22900, 23400)))
                                       : -$signed(16'($urandom_range(22900, 23400)));
            q.x = $signed(16'($urandom_range(0, 400))) - 16'sd200;
            q.z = $signed(16'($urandom_range(0, 400))) - 16'sd200;
         end
         default: begin
            q.x = q.x >>> $urandom_range(0, 3);
            q.y = q.y >>> $urandom_range(0, 3);
            q.z = q.z >>> $urandom_range(0, 3);
         end
      endcase
      return q;
   endfunction

   // Acceptance is recorded at the rising edge; the prediction is made here.
   always @(posedge clock) begin
      quat_type qa;
      req_taken = req_tvalid && req_tready && !reset;
      if (req_taken) begin
         qa.x = req_tdata[15:0];
         qa.y = req_tdata[31:16];
         qa.z = req_tdata[47:32];
         qa.w = req_tdata[63:48];
         expected_angles.push_back(quat_to_euler(qa));
      end
   end

   always @(negedge clock) begin
      quat_type q;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (sent_count == 700 && expected_angles.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (pending_quats.size() != 0) begin
            q = pending_quats.pop_front();
            req_tdata  <= {q.w, q.z, q.y, q.x};
            req_tvalid <= 1'b1;
            sent_count++;
            req_gap = (sent_count >= 200 && sent_count < 400) ? 0 : pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!hold_done && result_count == 300) begin
         hold_done = 1'b1;
         rsp_hold = 400;
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = (result_count >= 500 && result_count < 700) ? 0 : pick_gap();
      end
   end

   always @(posedge clock) begin
      euler_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.roll    = rsp_tdata[15:0];
         got.pitch   = rsp_tdata[30:16];
         got.yaw     = rsp_tdata[46:31];
         got.clamped = rsp_tuser[0];
         result_count++;
         if (expected_angles.size() == 0) begin
            $display("%0t: unexpected result roll %0d pitch %0d yaw %0d clamped %0d",
                     $time, got.roll, got.pitch, got.yaw, got.clamped);
            failed = 1'b1;
         end else begin
            want = expected_angles.pop_front();
            if (got.roll !== want.roll || got.pitch !== want.pitch ||
                got.yaw !== want.yaw || got.clamped !== want.clamped) begin
               $display("%0t: mismatch expected roll %0d pitch %0d yaw %0d clamped %0d",
                        $time, want.roll, want.pitch, want.yaw, want.clamped);
               $display("%0t:          actual   roll %0d pitch %0d yaw %0d clamped %0d",
                        $time, got.roll, got.pitch, got.yaw, got.clamped);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      quat_type q;
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
      pending_quats.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
      pending_quats.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
      pending_quats.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767});
      pending_quats.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd32767});
      pending_quats.push_back('{16'sd0, -16'sd32768, 16'sd0, 16'sd32767});
      pending_quats.push_back('{16'sd0, 16'sd23170, 16'sd0, 16'sd23170});
      pending_quats.push_back('{16'sd0, 16'sd23171, 16'sd0, 16'sd23171});
      pending_quats.push_back('{16'sd0, -16'sd23171, 16'sd0, 16'sd23171});
      pending_quats.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0});
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'sd0});
      pending_quats.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd1});
      pending_quats.push_back('{16'sd32767, 16'sd0, 16'sd0, -16'sd1});
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd32767, -16'sd1});
      pending_quats.push_back('{16'sd23170, 16'sd0, 16'sd0, 16'sd23170});
      pending_quats.push_back('{-16'sd23170, 16'sd0, 16'sd0, 16'sd23170});
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd23170, -16'sd23170});
      pending_quats.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
      pending_quats.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
      for (int i = 0; i < 1250; i++) begin
         q = random_quat();
         pending_quats.push_back(q);
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (pending_quats.size() == 0 && !req_tvalid);
      wait (expected_angles.size() == 0);
      repeat (q2e_pkg::TOTAL_LAT * 2) @(posedge clock);
      if (!failed && expected_angles.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
